[rtl/akht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akht_pkg
// Shared types and constants for the address-keyed chained hash table unit.
// ----------------------------------------------------------------------------
package akht_pkg;

    localparam int TABLE_ENTRIES  = 256;
    localparam int IDX_W          = $clog2(TABLE_ENTRIES);
    localparam int CNT_W          = IDX_W + 1;
    localparam int MAX_HEAP_BYTES = 16777216;
    localparam int SIZE_W         = $clog2(MAX_HEAP_BYTES) + 1;
    localparam int SPAN_W         = SIZE_W - IDX_W;
    localparam int DSR_W          = SPAN_W + IDX_W;
    localparam int STEP_W         = $clog2(IDX_W + 1);

    typedef enum logic [1:0] {
        CMD_INIT   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_RSVD   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_REJECTED  = 3'd5,
        ST_INIT      = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        REG_HEAP_BASE  = 2'd0,
        REG_HEAP_END   = 2'd1,
        REG_HEAP_VALID = 2'd2
    } reg_idx_t;

    // Result of the bucket divider.
    typedef struct packed {
        logic             done;
        logic             over;
        logic [IDX_W-1:0] quotient;
    } div_res_t;

endpackage

[rtl/akht_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akht_div
// Iterative bucket divider: one compare and subtract per cycle.
// ----------------------------------------------------------------------------
module akht_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [31:0]                   dividend,
    input  logic [akht_pkg::SPAN_W-1:0]   span,
    output akht_pkg::div_res_t            res
);
    import akht_pkg::*;

    logic [31:0]       rem_reg, rem_next;
    logic [DSR_W-1:0]  dsr_reg, dsr_next;
    logic [IDX_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              over_reg, over_next;
    logic              ge;

    // The shared compare of the remainder against the shifted divisor.
    assign ge = rem_reg >= {{(32-DSR_W){1'b0}}, dsr_reg};

    // The first step only tests whether the quotient exceeds the table.
    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        over_next = over_reg;
        if (start)
        begin
            rem_next  = dividend;
            dsr_next  = {span, {IDX_W{1'b0}}};
            quo_next  = '0;
            step_next = STEP_W'(IDX_W);
            busy_next = 1'b1;
            over_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_W'(IDX_W) && ge)
            begin
                over_next = 1'b1;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (step_reg != STEP_W'(IDX_W))
                begin
                    quo_next = {quo_reg[IDX_W-2:0], ge};
                    if (ge)
                    begin
                        rem_next = rem_reg - {{(32-DSR_W){1'b0}}, dsr_reg};
                    end
                end
                dsr_next = dsr_reg >> 1;
                if (step_reg == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        over_reg <= over_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign res.done     = done_reg;
    assign res.over     = over_reg;
    assign res.quotient = quo_reg;

endmodule

[rtl/address_keyed_chained_hash_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_keyed_chained_hash_table_unit
// Table of object addresses and types, bucketed by address and chained.
// ----------------------------------------------------------------------------
// One transaction at a time; in_ready stays low from acceptance until the
// result is loaded into the output register. Init and commands rejected on
// acceptance go straight to delivery; an address whose bucket lies beyond
// the table is rejected by the first divider step. Insert and find run the
// 9-step bucket divider and test the bucket valid flag; on a chain they read
// the head, then read (a registered memory read) and compare each entry in
// turn. An append writes the new entry and, when it links onto a chain, the
// old tail's link as well. A stalled result waits in the delivery state.
// Init empties the table at once (bucket valid flags and a fill count), with
// no clearing pass.
module address_keyed_chained_hash_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] object_type,
    input  logic [31:0] object_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  entry_index,
    output logic [31:0] entry_type
);
    import akht_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_HEAD, S_HEAD2, S_READ, S_CMP, S_APPEND, S_LINKUP, S_DELIVER
    } state_t;

    state_t               state_reg, state_next;
    logic [31:0]          base_reg, end_reg;
    logic                 hvalid_reg;
    logic [SPAN_W-1:0]    span_reg, span_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TABLE_ENTRIES-1:0] bvalid_reg, bvalid_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [31:0]          kind_reg, kind_next, addr_reg, addr_next;
    logic [IDX_W-1:0]     bucket_reg, bucket_next, cur_reg, cur_next;
    logic                 chain_reg, chain_next;
    logic [2:0]           rst_reg, rst_next;
    logic [IDX_W-1:0]     ridx_reg, ridx_next;
    logic [31:0]          rtype_reg, rtype_next;
    logic                 ov_reg, ov_next;
    logic [2:0]           ost_reg, ost_next;
    logic [IDX_W-1:0]     oidx_reg, oidx_next;
    logic [31:0]          otype_reg, otype_next;

    // Memories.
    logic [IDX_W-1:0] head_mem [TABLE_ENTRIES];
    logic [31:0]      key_mem  [TABLE_ENTRIES];
    logic [31:0]      kind_mem [TABLE_ENTRIES];
    logic [IDX_W-1:0] link_mem [TABLE_ENTRIES];
    logic [IDX_W-1:0] head_q, link_q;
    logic [31:0]      key_q, kindm_q;

    logic             div_start;
    div_res_t         div_res;
    logic [31:0]      ext_diff;
    logic [SIZE_W-1:0] size_v;
    logic [SIZE_W:0]  size_rnd;
    logic             accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    akht_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (addr_reg - base_reg),
        .span     (span_reg),
        .res      (div_res)
    );

    // Span from the heap extent, rounded up to whole buckets.
    assign ext_diff = end_reg - base_reg;
    always_comb
    begin
        if (hvalid_reg && end_reg > base_reg && ext_diff < 32'(MAX_HEAP_BYTES))
        begin
            size_v = ext_diff[SIZE_W-1:0];
        end
        else
        begin
            size_v = SIZE_W'(MAX_HEAP_BYTES);
        end
        size_rnd = {1'b0, size_v} + (SIZE_W+1)'(TABLE_ENTRIES - 1);
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        span_next   = span_reg;
        count_next  = count_reg;
        bvalid_next = bvalid_reg;
        cmd_next    = cmd_reg;
        kind_next   = kind_reg;
        addr_next   = addr_reg;
        bucket_next = bucket_reg;
        cur_next    = cur_reg;
        chain_next  = chain_reg;
        rst_next    = rst_reg;
        ridx_next   = ridx_reg;
        rtype_next  = rtype_reg;
        ov_next     = ov_reg;
        ost_next    = ost_reg;
        oidx_next   = oidx_reg;
        otype_next  = otype_reg;
        div_start   = 1'b0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = command;
                    kind_next  = object_type;
                    addr_next  = object_addr;
                    ridx_next  = '0;
                    rtype_next = '0;
                    state_next = S_DELIVER;
                    if (command == CMD_INIT)
                    begin
                        bvalid_next = '0;
                        count_next  = '0;
                        span_next   = size_rnd[SIZE_W-1:IDX_W];
                        rst_next    = ST_INIT;
                    end
                    else if (command == CMD_RSVD || span_reg == '0 ||
                             object_addr == '0 || !hvalid_reg)
                    begin
                        rst_next = ST_REJECTED;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                // Start pulses on the first cycle, while the divider is idle.
                div_start = !chain_reg;
                chain_next = 1'b1;
                if (div_res.done)
                begin
                    chain_next = 1'b0;
                    if (div_res.over)
                    begin
                        rst_next   = ST_REJECTED;
                        state_next = S_DELIVER;
                    end
                    else
                    begin
                        bucket_next = div_res.quotient;
                        state_next  = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                if (bvalid_reg[bucket_reg])
                begin
                    state_next = S_HEAD2;
                end
                else if (cmd_reg == CMD_FIND)
                begin
                    rst_next   = ST_NOT_FOUND;
                    state_next = S_DELIVER;
                end
                else if (count_reg[IDX_W])
                begin
                    rst_next   = ST_FULL;
                    state_next = S_DELIVER;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_HEAD2:
            begin
                cur_next   = head_q;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (key_q == addr_reg)
                begin
                    rst_next   = (cmd_reg == CMD_FIND) ? ST_FOUND : ST_PRESENT;
                    ridx_next  = cur_reg;
                    rtype_next = kindm_q;
                    state_next = S_DELIVER;
                end
                else if (link_q != '0)
                begin
                    cur_next   = link_q;
                    state_next = S_READ;
                end
                else if (cmd_reg == CMD_FIND)
                begin
                    rst_next   = ST_NOT_FOUND;
                    state_next = S_DELIVER;
                end
                else if (count_reg[IDX_W])
                begin
                    rst_next   = ST_FULL;
                    state_next = S_DELIVER;
                end
                else
                begin
                    chain_next = 1'b1;
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                rst_next   = ST_INSERTED;
                ridx_next  = count_reg[IDX_W-1:0];
                rtype_next = kind_reg;
                count_next = count_reg + 1'b1;
                if (chain_reg)
                begin
                    state_next = S_LINKUP;
                end
                else
                begin
                    bvalid_next[bucket_reg] = 1'b1;
                    state_next = S_DELIVER;
                end
            end
            S_LINKUP:
            begin
                chain_next = 1'b0;
                state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ost_next   = rst_reg;
                    oidx_next  = ridx_reg;
                    otype_next = rtype_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration, state and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            base_reg   <= '0;
            end_reg    <= '0;
            hvalid_reg <= 1'b0;
            span_reg   <= '0;
            count_reg  <= '0;
            bvalid_reg <= '0;
            chain_reg  <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            span_reg   <= span_next;
            count_reg  <= count_next;
            bvalid_reg <= bvalid_next;
            chain_reg  <= chain_next;
            ov_reg     <= ov_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_HEAP_BASE:  base_reg   <= cfg_wdata;
                    REG_HEAP_END:   end_reg    <= cfg_wdata;
                    REG_HEAP_VALID: hvalid_reg <= cfg_wdata[0];
                    default:        ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        kind_reg   <= kind_next;
        addr_reg   <= addr_next;
        bucket_reg <= bucket_next;
        cur_reg    <= cur_next;
        rst_reg    <= rst_next;
        ridx_reg   <= ridx_next;
        rtype_reg  <= rtype_next;
        ost_reg    <= ost_next;
        oidx_reg   <= oidx_next;
        otype_reg  <= otype_next;
    end

    // Bucket head memory.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_APPEND && !chain_reg)
        begin
            head_mem[bucket_reg] <= count_reg[IDX_W-1:0];
        end
        head_q <= head_mem[bucket_reg];
    end

    // Entry memories; a new entry ends its chain until it is linked onward.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_APPEND)
        begin
            key_mem[count_reg[IDX_W-1:0]]  <= addr_reg;
            kind_mem[count_reg[IDX_W-1:0]] <= kind_reg;
        end
        key_q   <= key_mem[cur_reg];
        kindm_q <= kind_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_APPEND)
        begin
            link_mem[count_reg[IDX_W-1:0]] <= '0;
        end
        else if (state_reg == S_LINKUP)
        begin
            link_mem[cur_reg] <= ridx_reg;
        end
        link_q <= link_mem[cur_reg];
    end

    assign out_valid   = ov_reg;
    assign status      = ost_reg;
    assign entry_index = oidx_reg;
    assign entry_type  = otype_reg;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table unit testbench
// Drives init, insert, find and reserved commands into the address-keyed
// chained hash table under several heap settings and idle patterns. A local table
// model predicts status, index and type of each result for in-order checking.
// ----------------------------------------------------------------------------
module tb;
    import akht_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] kind;
        logic [31:0] addr;
    } table_op_t;

    typedef struct {
        status_t     st;
        logic [7:0]  idx;
        logic [31:0] kind;
    } table_reply_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [31:0] object_type;
    logic [31:0] object_addr;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [7:0]  entry_index;
    logic [31:0] entry_type;

    address_keyed_chained_hash_table_unit dut (.*);

    // Local copy of the table and its configuration.
    logic [31:0] mdl_base;
    logic [31:0] mdl_end;
    logic        mdl_valid;
    logic [8:0]  mdl_head [TABLE_ENTRIES];
    logic [31:0] mdl_key  [TABLE_ENTRIES];
    logic [31:0] mdl_kind [TABLE_ENTRIES];
    logic [7:0]  mdl_link [TABLE_ENTRIES];
    int          mdl_count;
    logic [31:0] mdl_span;

    table_op_t    pending_ops[$];
    table_reply_t expected_replies[$];
    logic [31:0]  known_addrs[$];
    int           mismatches;
    int           send_idle_pct;
    int           recv_stall_pct;
    logic         in_fire;
    longint       cycles;

    always #CLK_HALF clk = ~clk;

    function automatic void clear_model();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            mdl_head[i] = 9'h100;
            mdl_key[i]  = '0;
            mdl_kind[i] = '0;
            mdl_link[i] = '0;
        end
        mdl_count = 0;
    endfunction

    function automatic int add_entry(logic [31:0] kind, logic [31:0] addr);
        int n;
        n = mdl_count;
        mdl_key[n]  = addr;
        mdl_kind[n] = kind;
        mdl_link[n] = '0;
        mdl_count++;
        return n;
    endfunction

    // Apply one transaction to the table copy and return its expected result.
    function automatic table_reply_t table_lookup(table_op_t op);
        table_reply_t r;
        logic [31:0]  size;
        logic [31:0]  bucket;
        int           cur;
        int           n;
        bit           hit;
        r.st   = ST_REJECTED;
        r.idx  = '0;
        r.kind = '0;
        hit    = 0;
        if (op.cmd == CMD_INIT) begin
            clear_model();
            size = MAX_HEAP_BYTES;
            if (mdl_valid && mdl_end > mdl_base && (mdl_end - mdl_base) < MAX_HEAP_BYTES)
                size = mdl_end - mdl_base;
            mdl_span = (size + TABLE_ENTRIES - 1) / TABLE_ENTRIES;
            r.st = ST_INIT;
            return r;
        end
        if (op.cmd == CMD_RSVD || mdl_span == 0 || op.addr == 0 || !mdl_valid)
            return r;
        bucket = (op.addr - mdl_base) / mdl_span;
        if (bucket >= TABLE_ENTRIES)
            return r;
        // Empty bucket: find misses, insert starts a new chain unless the table is full.
        if (mdl_head[bucket][8]) begin
            if (op.cmd == CMD_FIND) begin
                r.st = ST_NOT_FOUND;
            end
            else if (mdl_count >= TABLE_ENTRIES) begin
                r.st = ST_FULL;
            end
            else begin
                n = add_entry(op.kind, op.addr);
                mdl_head[bucket] = 9'(n);
                r.st   = ST_INSERTED;
                r.idx  = 8'(n);
                r.kind = op.kind;
            end
            return r;
        end
        // Walk the chain looking for the address.
        cur = mdl_head[bucket][7:0];
        for (int s = 0; s < TABLE_ENTRIES; s++) begin
            if (mdl_key[cur] == op.addr) begin
                hit = 1;
                break;
            end
            if (mdl_link[cur] == 0)
                break;
            cur = mdl_link[cur];
        end
        if (hit) begin
            r.st   = (op.cmd == CMD_FIND) ? ST_FOUND : ST_PRESENT;
            r.idx  = 8'(cur);
            r.kind = mdl_kind[cur];
        end
        else if (op.cmd == CMD_FIND) begin
            r.st = ST_NOT_FOUND;
        end
        else if (mdl_count >= TABLE_ENTRIES) begin
            r.st = ST_FULL;
        end
        else begin
            n = add_entry(op.kind, op.addr);
            mdl_link[cur] = 8'(n);
            r.st   = ST_INSERTED;
            r.idx  = 8'(n);
            r.kind = op.kind;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // Cycle counter and run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Monitor: predict on accepted input, check accepted results in order.
    always @(posedge clk)
    begin
        table_reply_t want;
        table_op_t    op;
        if (rst_n) begin
            in_fire <= in_valid && in_ready;
            if (out_valid && out_ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected result", 32'(status), '0);
                end
                else begin
                    want = expected_replies.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", 32'(status), 32'(want.st));
                    if (entry_index !== want.idx)
                        report_mismatch("entry_index", 32'(entry_index), 32'(want.idx));
                    if (entry_type !== want.kind)
                        report_mismatch("entry_type", entry_type, want.kind);
                end
            end
            if (in_valid && in_ready) begin
                op.cmd  = cmd_t'(command);
                op.kind = object_type;
                op.addr = object_addr;
                expected_replies.push_back(table_lookup(op));
            end
        end
    end

    // Driver: present pending transactions and toggle the result-side ready.
    always @(negedge clk)
    begin
        table_op_t op;
        if (rst_n) begin
            if (!in_valid || in_fire) begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    op = pending_ops.pop_front();
                    in_valid    <= 1'b1;
                    command     <= op.cmd;
                    object_type <= op.kind;
                    object_addr <= op.addr;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_HEAP_BASE:  mdl_base  = value;
            REG_HEAP_END:   mdl_end   = value;
            REG_HEAP_VALID: mdl_valid = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_heap(logic [31:0] base, logic [31:0] fend, logic valid);
        write_reg(REG_HEAP_BASE, base);
        write_reg(REG_HEAP_END, fend);
        write_reg(REG_HEAP_VALID, {31'b0, valid});
    endtask

    // Wait until every transaction is sent and answered, then let the unit settle.
    task automatic drain();
        while (pending_ops.size() > 0 || in_valid || expected_replies.size() > 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic push_op(cmd_t cmd, logic [31:0] kind, logic [31:0] addr);
        table_op_t op;
        op.cmd  = cmd;
        op.kind = kind;
        op.addr = addr;
        pending_ops.push_back(op);
    endtask

    // Random transaction, mostly aimed inside the tracked heap region.
    task automatic push_random(int init_pct, int insert_pct, int find_pct);
        int          r;
        int          a;
        logic [31:0] region;
        logic [31:0] addr;
        cmd_t        cmd;
        r = $urandom_range(99);
        if (r < init_pct)
            cmd = CMD_INIT;
        else if (r < init_pct + insert_pct)
            cmd = CMD_INSERT;
        else if (r < init_pct + insert_pct + find_pct)
            cmd = CMD_FIND;
        else
            cmd = CMD_RSVD;
        region = (mdl_span == 0) ? 32'd1024 : mdl_span * TABLE_ENTRIES;
        if (region > 32'd4096 && $urandom_range(1))
            region = 32'd4096;
        a = $urandom_range(99);
        if (a < 2)
            addr = '0;
        else if (a < 65)
            addr = mdl_base + $urandom_range(region - 1);
        else if (a < 85 && known_addrs.size() > 0)
            addr = known_addrs[$urandom_range(known_addrs.size() - 1)];
        else
            addr = $urandom;
        if (cmd == CMD_INSERT && known_addrs.size() < 512)
            known_addrs.push_back(addr);
        push_op(cmd, $urandom, addr);
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_addr = REG_HEAP_BASE;
        cfg_wdata = '0;
        in_valid = 0;
        command = CMD_INIT;
        object_type = '0;
        object_addr = '0;
        out_ready = 0;
        in_fire = 0;
        cycles = 0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mdl_base = '0;
        mdl_end = '0;
        mdl_valid = 0;
        mdl_span = '0;
        clear_model();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Before any setup: no span yet, then init with heap info invalid.
        push_op(CMD_FIND, 32'h0, 32'h5);
        push_op(CMD_INIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_op(CMD_INSERT, 32'h1, 32'h100);
        push_op(CMD_RSVD, 32'h0, 32'h100);
        drain();

        // Small heap, span of four bytes: chains, matches, misses, bounds.
        set_heap(32'h0001_0000, 32'h0001_0400, 1'b1);
        push_op(CMD_INIT, 32'h0, 32'h0);
        push_op(CMD_INSERT, 32'h7, 32'h0);
        push_op(CMD_INSERT, 32'hFFFF_FFFF, 32'h0001_0008);
        push_op(CMD_INSERT, 32'h0, 32'h0001_0008);
        push_op(CMD_FIND, 32'h1234_5678, 32'h0001_0008);
        push_op(CMD_FIND, 32'h0, 32'h0001_0009);
        push_op(CMD_INSERT, 32'hA5A5_A5A5, 32'h0001_0009);
        push_op(CMD_INSERT, 32'h5A5A_5A5A, 32'h0001_000B);
        push_op(CMD_FIND, 32'h0, 32'h0001_000B);
        push_op(CMD_FIND, 32'h0, 32'h0001_000A);
        push_op(CMD_INSERT, 32'h3, 32'h0000_FFFF);
        push_op(CMD_INSERT, 32'h4, 32'h0001_03FF);
        push_op(CMD_INSERT, 32'h5, 32'h0001_0400);
        push_op(CMD_FIND, 32'h0, 32'hFFFF_FFFF);
        push_op(CMD_RSVD, 32'hFFFF_FFFF, 32'h0001_0008);
        push_op(CMD_FIND, 32'h0, 32'h0001_0000);
        drain();

        // Fill the table with distinct addresses until it reports full.
        push_op(CMD_INIT, 32'h0, 32'h0);
        for (int k = 0; k < 280; k++) begin
            if (k % 20 == 19)
                push_op(CMD_FIND, $urandom, 32'h0001_0000 + 1 + (k * 37) % 1023);
            else
                push_op(CMD_INSERT, $urandom, 32'h0001_0000 + 1 + (k * 37) % 1023);
            if (k == 140) begin
                drain();
                send_idle_pct = 62;
            end
        end
        drain();

        // Several heap settings, cycling through idle and stall patterns.
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: set_heap(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
                1: set_heap(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
                2: set_heap(32'h8000_0000, 32'h8000_0000, 1'b1);
                3: set_heap(32'h1234_5000, 32'h1234_8000, 1'b0);
                default: set_heap(32'h1234_5000, 32'h1234_8000, 1'b1);
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            push_op(CMD_INIT, $urandom, $urandom);
            for (int k = 0; k < 60; k++)
                push_random(5, 50, 40);
            drain();
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
